// ===== hw/rtl/dcglfsr_pkg.sv =====
package dcglfsr_pkg;

  // Shifts performed per cycle by the advance datapath
  localparam int unsigned STEPS_PER_CYCLE = 8;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned STEP_W = 16;

  localparam logic [WORD_W-1:0] FEEDBACK_MASK  = 32'h8000_0057;
  localparam logic [WORD_W-1:0] MASKING_RESET  = 32'hdead_beef;
  localparam logic [WORD_W-1:0] ORDERING_RESET = 32'h9999_9999;

  // Operation codes
  localparam logic OP_SEED = 1'b0;
  localparam logic OP_NEXT = 1'b1;

  // Context codes
  localparam logic CTX_MASKING  = 1'b0;
  localparam logic CTX_ORDERING = 1'b1;

  localparam logic [STEP_W-1:0] CHUNK_MAX = STEP_W'(STEPS_PER_CYCLE);

  typedef struct packed {
    logic seed_wr;   // write seed into the requested context
    logic read_wr;   // capture the requested context and load the step count
    logic step;      // advance the selected context by one chunk
  } cmd_t;

  typedef struct packed {
    logic last_chunk;  // remaining shifts fit in one chunk
  } stat_t;

  function automatic logic [WORD_W-1:0] shift_once(input logic [WORD_W-1:0] s);
    logic [WORD_W-1:0] r;
    r = s >> 1;
    if (s[0]) begin
      r = r ^ FEEDBACK_MASK;
    end
    return r;
  endfunction

  // Apply n shifts, n no larger than STEPS_PER_CYCLE
  function automatic logic [WORD_W-1:0] shift_chunk(input logic [WORD_W-1:0] s,
                                                    input logic [STEP_W-1:0] n);
    logic [WORD_W-1:0] r;
    r = s;
    for (int i = 0; i < STEPS_PER_CYCLE; i++) begin
      if (STEP_W'(i) < n) begin
        r = shift_once(r);
      end
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/dcglfsr_ctrl.sv =====
module dcglfsr_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                operation,
  input  logic [15:0]         step_count,
  output logic                out_valid,
  input  logic                out_stall,
  output dcglfsr_pkg::cmd_t   cmd,
  input  dcglfsr_pkg::stat_t  stat
);
  import dcglfsr_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic st;
  logic st_next;
  logic accept;

  // Hold input while advancing or while a word waits with nowhere to go
  assign in_stall = (st == ST_RUN) || (out_valid && out_stall);
  assign accept   = in_valid && !in_stall;

  assign cmd.seed_wr = accept && (operation == OP_SEED);
  assign cmd.read_wr = accept && (operation == OP_NEXT);
  assign cmd.step    = (st == ST_RUN);

  always_comb begin
    st_next = st;
    unique case (st)
      ST_IDLE: begin
        if (cmd.read_wr && (step_count != '0)) begin
          st_next = ST_RUN;
        end
      end
      ST_RUN: begin
        if (stat.last_chunk) begin
          st_next = ST_IDLE;
        end
      end
      default: st_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      st <= st_next;
      if (cmd.read_wr) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_run_ends: assert property (@(posedge clk) disable iff (rst)
    (st == ST_RUN) && stat.last_chunk |=> (st == ST_IDLE))
    else $error("advance did not finish after last chunk");

  a_nonzero_runs: assert property (@(posedge clk) disable iff (rst)
    cmd.read_wr && (step_count != '0) |=> (st == ST_RUN))
    else $error("nonzero step count did not start advance");

  a_word_loaded: assert property (@(posedge clk) disable iff (rst)
    cmd.read_wr |=> out_valid)
    else $error("read did not present a word");

endmodule

// ===== hw/rtl/dcglfsr_dp.sv =====
module dcglfsr_dp (
  input  logic                clk,
  input  logic                rst,
  input  dcglfsr_pkg::cmd_t   cmd,
  output dcglfsr_pkg::stat_t  stat,
  input  logic                context_req,
  input  logic [31:0]         seed_value,
  input  logic [15:0]         step_count,
  output logic [31:0]         random_word
);
  import dcglfsr_pkg::*;

  logic [WORD_W-1:0] masking_state;
  logic [WORD_W-1:0] ordering_state;
  logic [STEP_W-1:0] steps_left;
  logic              ctx_sel;
  logic [STEP_W-1:0] chunk;
  logic [WORD_W-1:0] cur_state;
  logic [WORD_W-1:0] adv_state;

  assign stat.last_chunk = (steps_left <= CHUNK_MAX);
  assign chunk     = stat.last_chunk ? steps_left : CHUNK_MAX;
  assign cur_state = (ctx_sel == CTX_MASKING) ? masking_state : ordering_state;
  assign adv_state = shift_chunk(cur_state, chunk);

  always_ff @(posedge clk) begin
    if (rst) begin
      masking_state  <= MASKING_RESET;
      ordering_state <= ORDERING_RESET;
      steps_left     <= '0;
      ctx_sel        <= CTX_MASKING;
    end else begin
      if (cmd.seed_wr) begin
        if (context_req == CTX_MASKING) begin
          masking_state <= seed_value;
        end else begin
          ordering_state <= seed_value;
        end
      end
      if (cmd.read_wr) begin
        steps_left <= step_count;
        ctx_sel    <= context_req;
      end else if (cmd.step) begin
        steps_left <= steps_left - chunk;
        if (ctx_sel == CTX_MASKING) begin
          masking_state <= adv_state;
        end else begin
          ordering_state <= adv_state;
        end
      end
    end
  end

  // Output word: state before advancing
  always_ff @(posedge clk) begin
    if (cmd.read_wr) begin
      random_word <= (context_req == CTX_MASKING) ? masking_state : ordering_state;
    end
  end

  a_step_has_work: assert property (@(posedge clk) disable iff (rst)
    cmd.step |-> (steps_left != '0))
    else $error("advance step with no shifts left");

  a_chunk_count: assert property (@(posedge clk) disable iff (rst)
    cmd.step && !stat.last_chunk |=> (steps_left == $past(steps_left) - CHUNK_MAX))
    else $error("step counter did not drop by a full chunk");

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    cmd.step |-> !(cmd.seed_wr || cmd.read_wr))
    else $error("new word accepted during advance");

endmodule

// ===== hw/rtl/dual_context_galois_lfsr.sv =====
// Two independent 32-bit right-shifting Galois LFSRs (feedback mask
// 0x80000057): context 0 feeds masking, context 1 feeds ordering. A seed
// word (operation 0) overwrites the chosen context's state and returns
// nothing. A next word (operation 1) returns the chosen context's state as
// it stood before the word, then advances that state by step_count shifts
// (zero leaves it unchanged). The advance datapath performs up to 8 shifts
// per clock, and a next word stalls the input until its advance is done;
// a seed word does not stall it. The returned word sits in an output
// register. While that word is held there by out_stall the input stalls,
// seed words included; a new word is taken in the same cycle the waiting
// word leaves. An all-zero state is a fixed point: the context returns
// zero until reseeded.
// Reset states are 0xdeadbeef (masking) and 0x99999999 (ordering).
module dual_context_galois_lfsr (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        operation,
  input  logic        context_req,
  input  logic [31:0] seed_value,
  input  logic [15:0] step_count,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] random_word
);
  import dcglfsr_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // Sequence accept, advance and output hand-off
  dcglfsr_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .operation  (operation),
    .step_count (step_count),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .cmd        (cmd),
    .stat       (stat)
  );

  // Hold both generator states, the step counter and the output word
  dcglfsr_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .context_req (context_req),
    .seed_value  (seed_value),
    .step_count  (step_count),
    .random_word (random_word)
  );

endmodule

// ===== dv/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import dcglfsr_pkg::*;

  // Longest quiet stretch a correct run can show: a next word with the full
  // step count keeps the input busy through its whole advance, plus a gap burst
  // on the input and a stall burst on the output. Allow several times that.
  localparam int unsigned QUIET_LIMIT    = 40000;
  localparam int unsigned RANDOM_WORDS   = 1500;
  localparam int unsigned CALM_TAIL      = 200;
  localparam int unsigned DRAIN_CYCLES   = 20;
  localparam int unsigned DIRECTED_WORDS = 24;

  // One row of the directed table. Where known is set, the returned word is
  // typed in; otherwise the predictor supplies it.
  typedef struct packed {
    logic              op;
    logic              ctx;
    logic [WORD_W-1:0] seed;
    logic [STEP_W-1:0] steps;
    logic              known;
    logic [WORD_W-1:0] word;
  } stim_row_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic              operation = OP_SEED;
  logic              context_req = CTX_MASKING;
  logic [WORD_W-1:0] seed_value = '0;
  logic [STEP_W-1:0] step_count = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [WORD_W-1:0] random_word;

  // Predicted generator states, one per context
  logic [WORD_W-1:0] mask_lfsr;
  logic [WORD_W-1:0] order_lfsr;

  // Words still owed by the block, oldest first
  logic [WORD_W-1:0] pending_words[$];

  int unsigned mismatch_count = 0;
  int unsigned quiet_cycles = 0;
  int unsigned stall_burst = 0;
  bit          pressure = 1'b0;

  stim_row_t directed_rows [0:DIRECTED_WORDS-1];

  dual_context_galois_lfsr dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .operation   (operation),
    .context_req (context_req),
    .seed_value  (seed_value),
    .step_count  (step_count),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .random_word (random_word)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Advance a Galois register by n right shifts: each time the bit falling
  // off the bottom is set, fold the feedback taps back in.
  function automatic logic [WORD_W-1:0] galois_advance(input logic [WORD_W-1:0] s,
                                                       input logic [STEP_W-1:0] n);
    logic [WORD_W-1:0] r;
    logic              low_bit;
    r = s;
    for (int unsigned k = 0; k < n; k++) begin
      low_bit = r[0];
      r = {1'b0, r[WORD_W-1:1]};
      if (low_bit) begin
        r = r ^ FEEDBACK_MASK;
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [WORD_W-1:0] got,
                                 input logic [WORD_W-1:0] want);
    $display("MISMATCH %s: random_word got %08h want %08h at %0t ns", what, got, want,
             $time);
    mismatch_count++;
  endtask

  // Offer one word on the input, hold it through any stall, and update the
  // predictor at the edge that accepts it.
  task automatic offer_word(input logic op, input logic ctx, input logic [WORD_W-1:0] seed,
                            input logic [STEP_W-1:0] steps, input logic known,
                            input logic [WORD_W-1:0] known_word);
    logic [WORD_W-1:0] prior;
    // Drop valid for a short burst now and then
    if (pressure && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid    <= 1'b1;
    operation   <= op;
    context_req <= ctx;
    seed_value  <= seed;
    step_count  <= steps;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (op == OP_SEED) begin
      // A seed only rewrites the chosen context; nothing comes back
      if (ctx == CTX_MASKING) mask_lfsr = seed;
      else order_lfsr = seed;
    end else begin
      // The word returned is the state before the advance
      prior = (ctx == CTX_MASKING) ? mask_lfsr : order_lfsr;
      pending_words.push_back(known ? known_word : prior);
      if (ctx == CTX_MASKING) mask_lfsr = galois_advance(prior, steps);
      else order_lfsr = galois_advance(prior, steps);
    end
  endtask

  // Output side: stall in random bursts while under pressure
  always @(posedge clk) begin
    if (rst || !pressure) begin
      out_stall   <= 1'b0;
      stall_burst <= 0;
    end else if (stall_burst != 0) begin
      out_stall   <= 1'b1;
      stall_burst <= stall_burst - 1;
    end else if ($urandom_range(0, 7) == 0) begin
      out_stall   <= 1'b1;
      stall_burst <= $urandom_range(0, 4);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Compare every accepted word with the oldest one owed
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_words.size() == 0) begin
        report_mismatch("word with nothing pending", random_word, '0);
      end else begin
        if (random_word !== pending_words[0]) begin
          report_mismatch("wrong word", random_word, pending_words[0]);
        end
        void'(pending_words.pop_front());
      end
    end
  end

  // Watchdog: end the run when nothing moves on either side for too long
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("dual_context_galois_lfsr test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic              r_op;
    logic              r_ctx;
    logic [WORD_W-1:0] r_seed;
    logic [STEP_W-1:0] r_steps;
    int unsigned       pick;

    // Directed part: reset values, zero and full step counts, the all-zero
    // fixed point, seeding the ordering context alone, ignored step count
    // on a seed and ignored seed on a next.
    directed_rows = '{
      '{OP_NEXT, CTX_MASKING,  32'h0000_0000, 16'd0,     1'b1, MASKING_RESET},
      '{OP_NEXT, CTX_ORDERING, 32'hffff_ffff, 16'd0,     1'b1, ORDERING_RESET},
      '{OP_NEXT, CTX_MASKING,  32'h0000_0000, 16'd1,     1'b1, MASKING_RESET},
      '{OP_NEXT, CTX_MASKING,  32'h0000_0000, 16'd0,     1'b0, 32'h0},
      '{OP_SEED, CTX_ORDERING, 32'h1234_5678, 16'd0,     1'b0, 32'h0},
      '{OP_NEXT, CTX_MASKING,  32'h0000_0000, 16'd0,     1'b0, 32'h0},
      '{OP_NEXT, CTX_ORDERING, 32'h0000_0000, 16'd0,     1'b1, 32'h1234_5678},
      '{OP_SEED, CTX_MASKING,  32'h0000_0000, 16'hffff,  1'b0, 32'h0},
      '{OP_NEXT, CTX_MASKING,  32'hffff_ffff, 16'hffff,  1'b1, 32'h0000_0000},
      '{OP_NEXT, CTX_MASKING,  32'h0000_0000, 16'd7,     1'b1, 32'h0000_0000},
      '{OP_SEED, CTX_MASKING,  32'hffff_ffff, 16'd0,     1'b0, 32'h0},
      '{OP_NEXT, CTX_MASKING,  32'h0000_0000, 16'd8,     1'b1, 32'hffff_ffff},
      '{OP_NEXT, CTX_MASKING,  32'h0000_0000, 16'd9,     1'b0, 32'h0},
      '{OP_SEED, CTX_ORDERING, 32'h0000_0001, 16'd0,     1'b0, 32'h0},
      '{OP_NEXT, CTX_ORDERING, 32'h0000_0000, 16'd1,     1'b1, 32'h0000_0001},
      '{OP_NEXT, CTX_ORDERING, 32'h0000_0000, 16'd0,     1'b1, FEEDBACK_MASK},
      '{OP_SEED, CTX_ORDERING, 32'h8000_0000, 16'd0,     1'b0, 32'h0},
      '{OP_NEXT, CTX_ORDERING, 32'h0000_0000, 16'hffff,  1'b1, 32'h8000_0000},
      '{OP_NEXT, CTX_ORDERING, 32'h0000_0000, 16'd16,    1'b0, 32'h0},
      '{OP_SEED, CTX_MASKING,  32'ha5a5_a5a5, 16'hffff,  1'b0, 32'h0},
      '{OP_NEXT, CTX_MASKING,  32'h0000_0000, 16'd0,     1'b1, 32'ha5a5_a5a5},
      '{OP_NEXT, CTX_ORDERING, 32'h5a5a_5a5a, 16'hffff,  1'b0, 32'h0},
      '{OP_NEXT, CTX_MASKING,  32'h0000_0000, 16'd15,    1'b0, 32'h0},
      '{OP_NEXT, CTX_MASKING,  32'h0000_0000, 16'd0,     1'b0, 32'h0}
    };

    mask_lfsr  = MASKING_RESET;
    order_lfsr = ORDERING_RESET;

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    pressure = 1'b1;
    foreach (directed_rows[i]) begin
      offer_word(directed_rows[i].op, directed_rows[i].ctx, directed_rows[i].seed,
                 directed_rows[i].steps, directed_rows[i].known, directed_rows[i].word);
    end

    // Random part. Most next words use short step counts; a few reach the
    // full 16-bit range so every step_count bit gets exercised.
    for (int unsigned n = 0; n < RANDOM_WORDS; n++) begin
      // Switch pressure on and off in blocks, and hold it off at the tail
      if (n % 50 == 0) pressure = ($urandom_range(0, 2) != 0);
      if (n >= RANDOM_WORDS - CALM_TAIL) pressure = 1'b0;

      r_op  = ($urandom_range(0, 3) == 0) ? OP_SEED : OP_NEXT;
      r_ctx = $urandom_range(0, 1) ? CTX_ORDERING : CTX_MASKING;

      pick = $urandom_range(0, 19);
      if (pick == 0) r_seed = '0;
      else if (pick == 1) r_seed = '1;
      else r_seed = $urandom;

      pick = $urandom_range(0, 99);
      if (pick < 70) r_steps = STEP_W'($urandom_range(0, 15));
      else if (pick < 90) r_steps = STEP_W'($urandom_range(16, 255));
      else if (pick < 97) r_steps = STEP_W'($urandom_range(256, 4095));
      else r_steps = STEP_W'($urandom_range(0, 65535));

      offer_word(r_op, r_ctx, r_seed, r_steps, 1'b0, '0);
    end
    in_valid <= 1'b0;

    // Drain what is owed, then give stray words a chance to show up
    while (pending_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("dual_context_galois_lfsr test passed");
    end else begin
      $display("dual_context_galois_lfsr test failed");
    end
    $finish;
  end

endmodule
